// File: rtl/kocnt_pkg.sv
// Package: keyword table, shared widths, queue command and back-end state types.
`default_nettype none
package kocnt_pkg;

   localparam int NUM_KEYWORDS    = 9;
   localparam int KW_IDX_W        = 4;
   localparam int KW_ROW          = 8;
   localparam int WORD_LEN_W      = 7;
   localparam int MAX_WORD_LEN    = 99;
   localparam int DEF_COUNT_WIDTH = 32;
   localparam int HIT_COUNT_W     = 32;
   localparam int CHAR_W          = 8;
   // must be a power of two
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [NUM_KEYWORDS-1:0] ALL_LIVE = '1;

   typedef struct packed {
      logic                has_match;
      logic [KW_IDX_W-1:0] kw_idx;
      logic                flush;
   } cmd_type;

   typedef enum logic [0:0] {
      BACK_IDLE,
      BACK_REPORT
   } back_state_type;

   // keyword text, right-justified, first character in the highest used byte
   function automatic logic [8*KW_ROW-1:0] kw_text(input logic [KW_IDX_W-1:0] k);
      logic [8*KW_ROW-1:0] t;
      unique case (k)
         4'd0:    t = 64'("auto");
         4'd1:    t = 64'("break");
         4'd2:    t = 64'("case");
         4'd3:    t = 64'("char");
         4'd4:    t = 64'("const");
         4'd5:    t = 64'("continue");
         4'd6:    t = 64'("default");
         4'd7:    t = 64'("void");
         4'd8:    t = 64'("while");
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [WORD_LEN_W-1:0] kw_len(input logic [KW_IDX_W-1:0] k);
      logic [WORD_LEN_W-1:0] n;
      unique case (k)
         4'd0:    n = 7'd4;
         4'd1:    n = 7'd5;
         4'd2:    n = 7'd4;
         4'd3:    n = 7'd4;
         4'd4:    n = 7'd5;
         4'd5:    n = 7'd8;
         4'd6:    n = 7'd7;
         4'd7:    n = 7'd4;
         4'd8:    n = 7'd5;
         default: n = '0;
      endcase
      return n;
   endfunction

   // character p of keyword k; only meaningful for p below the keyword length
   function automatic logic [CHAR_W-1:0] kw_char(input logic [KW_IDX_W-1:0] k,
                                                 input logic [2:0] p);
      logic [8*KW_ROW-1:0] t;
      logic [2:0]          pos;
      t   = kw_text(k);
      pos = 3'(kw_len(k) - WORD_LEN_W'(p) - WORD_LEN_W'(1));
      return t[8*pos +: 8];
   endfunction

endpackage
`default_nettype wire

// File: rtl/kocnt_req_if.sv
// Interface: input channel carrying one character byte or an end-of-input mark.
`default_nettype none
interface kocnt_req_if;
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [kocnt_pkg::CHAR_W-1:0] char_byte;

   modport source (output valid, output op, output char_byte, input ready);
   modport sink   (input valid, input op, input char_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/kocnt_rsp_if.sv
// Interface: result channel carrying keyword matches and report entries.
`default_nettype none
interface kocnt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [kocnt_pkg::KW_IDX_W-1:0]    keyword_index;
   logic [kocnt_pkg::HIT_COUNT_W-1:0] hit_count;
   logic                              is_report;
   logic                              last;

   modport source (output valid, output keyword_index, output hit_count,
                   output is_report, output last, input ready);
   modport sink   (input valid, input keyword_index, input hit_count,
                   input is_report, input last, output ready);
endinterface
`default_nettype wire

// File: rtl/keyword_occurrence_counter.sv
// Keyword occurrence counter. Bytes enter one per cycle on req_bus while the command queue has
// room; words are letters followed by letters or digits, cut at MAX_WORD_LEN characters, and
// each finished word that equals one of auto, break, case, char, const, continue, default, void,
// while (indices 0 to 8) bumps that keyword's saturating counter and yields one match entry on
// rsp_bus. An end-of-input item completes a pending word and then reports every nonzero counter
// in table order, the last entry flagged. The front end takes one byte per cycle as long as its
// four-entry command queue has room; the back end drains one command per cycle while its output
// register is free and takes no command while it walks the report. Counters clear only at reset.
`default_nettype none
module keyword_occurrence_counter #(
   parameter int COUNT_WIDTH = kocnt_pkg::DEF_COUNT_WIDTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   kocnt_req_if.sink   req_bus,
   kocnt_rsp_if.source rsp_bus
);
   import kocnt_pkg::*;

   cmd_type push_cmd, head_cmd;
   logic    push, pop, full, empty;

   kocnt_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .cmd     (push_cmd),
      .push    (push),
      .full    (full)
   );

   kocnt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (full),
      .pop       (pop),
      .head      (head_cmd),
      .empty     (empty)
   );

   kocnt_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head_cmd),
      .empty   (empty),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule
`default_nettype wire

// File: rtl/kocnt_front.sv
// Front end: splits the byte stream into words and matches them against the keyword table.
`default_nettype none
module kocnt_front (
   input  wire logic               clock,
   input  wire logic               reset,
   kocnt_req_if.sink               req_bus,
   output kocnt_pkg::cmd_type      cmd,
   output logic                    push,
   input  wire logic               full
);
   import kocnt_pkg::*;

   logic                    in_word_ff, in_word_in;
   logic [WORD_LEN_W-1:0]   len_ff, len_in;
   logic [NUM_KEYWORDS-1:0] live_ff, live_in;

   logic                    accept;
   logic                    is_letter, is_digit, advance, end_word, hit;
   logic [WORD_LEN_W-1:0]   base_len, adv_len, fin_len;
   logic [NUM_KEYWORDS-1:0] base_live, adv_live, fin_live;
   logic [KW_IDX_W-1:0]     hit_idx;
   logic [CHAR_W-1:0]       c;

   assign req_bus.ready = !full;
   assign accept        = req_bus.valid && !full;
   assign c             = req_bus.char_byte;

   always_comb begin
      is_letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      is_digit  = (c >= "0" && c <= "9");
      advance   = !req_bus.op && (in_word_ff ? (is_letter || is_digit) : is_letter);

      // a new word starts from a full candidate set
      base_live = in_word_ff ? live_ff : ALL_LIVE;
      base_len  = in_word_ff ? len_ff : '0;
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         adv_live[k] = base_live[k] && (base_len < kw_len(KW_IDX_W'(k)))
                    && (kw_char(KW_IDX_W'(k), base_len[2:0]) == c);
      end
      adv_len = base_len + WORD_LEN_W'(1);

      fin_live = advance ? adv_live : live_ff;
      fin_len  = advance ? adv_len : len_ff;

      if (req_bus.op) begin
         end_word = in_word_ff;
      end else begin
         end_word = (in_word_ff && !advance)
                 || (advance && adv_len >= WORD_LEN_W'(MAX_WORD_LEN));
      end

      hit     = 1'b0;
      hit_idx = '0;
      for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
         if (fin_live[k] && fin_len == kw_len(KW_IDX_W'(k))) begin
            hit     = 1'b1;
            hit_idx = KW_IDX_W'(k);
         end
      end

      priority if (end_word) begin
         in_word_in = 1'b0;
         len_in     = '0;
         live_in    = ALL_LIVE;
      end else if (advance) begin
         in_word_in = 1'b1;
         len_in     = adv_len;
         live_in    = adv_live;
      end else begin
         in_word_in = in_word_ff;
         len_in     = len_ff;
         live_in    = live_ff;
      end

      cmd.has_match = end_word && hit;
      cmd.kw_idx    = hit_idx;
      cmd.flush     = req_bus.op;
      push          = accept && (cmd.has_match || cmd.flush);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff <= 1'b0;
         len_ff     <= '0;
         live_ff    <= ALL_LIVE;
      end else if (accept) begin
         in_word_ff <= in_word_in;
         len_ff     <= len_in;
         live_ff    <= live_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/kocnt_queue.sv
// Command queue between the word front end and the counting back end.
`default_nettype none
module kocnt_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire kocnt_pkg::cmd_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output kocnt_pkg::cmd_type      head,
   output logic                    empty
);
   import kocnt_pkg::*;

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   assign full  = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign empty = (fill_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in   = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in   = pop ? rd_ff + PTR_W'(1) : rd_ff;
      fill_in = fill_ff;
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + FILL_W'(1);
         2'b01:   fill_in = fill_ff - FILL_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: rtl/kocnt_back.sv
// Back end: updates the saturating counters, emits matches and walks the final report.
`default_nettype none
module kocnt_back #(
   parameter int COUNT_WIDTH = kocnt_pkg::DEF_COUNT_WIDTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire kocnt_pkg::cmd_type head,
   input  wire logic               empty,
   output logic                    pop,
   kocnt_rsp_if.source             rsp_bus
);
   import kocnt_pkg::*;

   back_state_type           state_ff, state_in;
   logic [KW_IDX_W-1:0]      walk_ff, walk_in;
   logic [COUNT_WIDTH-1:0]   cnt_ff [NUM_KEYWORDS];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [KW_IDX_W-1:0]      rsp_idx_ff, rsp_idx_in;
   logic [HIT_COUNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;
   logic                     rsp_rep_ff, rsp_rep_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     out_free, load, cnt_we, found, more;
   logic [KW_IDX_W-1:0]      next_idx, sel;
   logic [COUNT_WIDTH-1:0]   cnt_rd, cnt_inc, cnt_out;
   logic [COUNT_WIDTH+HIT_COUNT_W-1:0] cnt_ext;

   assign out_free              = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.keyword_index = rsp_idx_ff;
   assign rsp_bus.hit_count     = rsp_cnt_ff;
   assign rsp_bus.is_report     = rsp_rep_ff;
   assign rsp_bus.last          = rsp_last_ff;

   always_comb begin
      // next nonzero counter at or after the walk position
      found    = 1'b0;
      next_idx = '0;
      for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
         if ((|cnt_ff[k]) && KW_IDX_W'(k) >= walk_ff) begin
            found    = 1'b1;
            next_idx = KW_IDX_W'(k);
         end
      end
      more = 1'b0;
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         if ((|cnt_ff[k]) && KW_IDX_W'(k) > next_idx) begin
            more = 1'b1;
         end
      end

      sel     = (state_ff == BACK_IDLE) ? head.kw_idx : next_idx;
      cnt_rd  = cnt_ff[sel];
      cnt_inc = (&cnt_rd) ? cnt_rd : cnt_rd + COUNT_WIDTH'(1);

      state_in     = state_ff;
      walk_in      = walk_ff;
      pop          = 1'b0;
      load         = 1'b0;
      cnt_we       = 1'b0;
      cnt_out      = cnt_rd;
      rsp_idx_in   = rsp_idx_ff;
      rsp_rep_in   = rsp_rep_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      unique case (state_ff)
         BACK_IDLE: begin
            if (!empty && out_free) begin
               pop = 1'b1;
               if (head.has_match) begin
                  cnt_we      = 1'b1;
                  load        = 1'b1;
                  cnt_out     = cnt_inc;
                  rsp_idx_in  = head.kw_idx;
                  rsp_rep_in  = 1'b0;
                  rsp_last_in = 1'b0;
               end
               if (head.flush) begin
                  state_in = BACK_REPORT;
                  walk_in  = '0;
               end
            end
         end
         BACK_REPORT: begin
            if (!found) begin
               state_in = BACK_IDLE;
            end else if (out_free) begin
               load        = 1'b1;
               rsp_idx_in  = next_idx;
               rsp_rep_in  = 1'b1;
               rsp_last_in = !more;
               walk_in     = next_idx + KW_IDX_W'(1);
               if (!more) begin
                  state_in = BACK_IDLE;
               end
            end
         end
         default: state_in = BACK_IDLE;
      endcase

      // counts narrower than the result field are zero-extended
      cnt_ext    = {{HIT_COUNT_W{1'b0}}, cnt_out};
      rsp_cnt_in = load ? cnt_ext[HIT_COUNT_W-1:0] : rsp_cnt_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_KEYWORDS; k++) begin
            cnt_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_we) begin
            cnt_ff[sel] <= cnt_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_idx_ff  <= rsp_idx_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_rep_ff  <= rsp_rep_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule
`default_nettype wire
